// ===== src/brf_pkg.sv =====
// Shared types, widths and codes for the byte ring FIFO frame extractor.
// Used by the channel interfaces and by every module of the block.
`default_nettype none

package brf_pkg;

  localparam int DEPTH_DEF   = 64;
  localparam int BYTE_W      = 8;
  localparam int FILL_W      = 6;
  localparam int ACT_W       = 2;
  localparam int MODE_W      = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int SHORT_FRAME = 2;

  // Action codes.
  localparam logic [ACT_W-1:0] ACT_PUSH    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_POP     = 2'd1;
  localparam logic [ACT_W-1:0] ACT_EXTRACT = 2'd2;
  localparam logic [ACT_W-1:0] ACT_NOP     = 2'd3;

  // Frame modes.
  localparam logic [MODE_W-1:0] MODE_PAIR   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SPLIT  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SINGLE = 2'd2;
  localparam logic [MODE_W-1:0] MODE_DOUBLE = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_CHAR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_END_CHAR   = 2'd2;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [BYTE_W-1:0] data_byte;
    logic [FILL_W-1:0] max_len;
  } cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] frame_mode;
    logic [BYTE_W-1:0] start_char;
    logic [BYTE_W-1:0] end_char;
  } cfg_t;

endpackage

`default_nettype wire

// ===== src/brf_ifs.sv =====
// Channel interfaces of the frame extractor: input words, result words and
// configuration writes. Depends on brf_pkg for the field widths.
`default_nettype none

interface brf_in_if import brf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  action;
  logic [BYTE_W-1:0] data_byte;
  logic [FILL_W-1:0] max_len;

  modport source (output valid, action, data_byte, max_len, input ready);
  modport sink   (input valid, action, data_byte, max_len, output ready);
endinterface

interface brf_out_if import brf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              byte_valid;
  logic              last;
  logic              push_accepted;
  logic [FILL_W-1:0] fill_count;

  modport source (output valid, out_byte, byte_valid, last, push_accepted, fill_count,
                  input ready);
  modport sink   (input valid, out_byte, byte_valid, last, push_accepted, fill_count,
                  output ready);
endinterface

interface brf_cfg_if import brf_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [BYTE_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== src/brf_front.sv =====
// Front end: accepts input words, classifies the action and queues commands.
// Depends on brf_pkg and brf_in_if.
`default_nettype none

module brf_front import brf_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  brf_in_if.sink    in_ch,
  output logic      cmd_vld,
  output cmd_t      cmd,
  input  wire logic cmd_take
);

  cmd_t              q_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;
  logic              push, pop;
  cmd_t              in_cmd;

  assign in_ch.ready = (cnt_r != (QPTR_W+1)'(QUEUE_DEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign pop         = cmd_take && cmd_vld;
  assign cmd_vld     = (cnt_r != '0);
  assign cmd         = q_r[rd_ptr_r];

  // Unused action code becomes an explicit no-op so the back end sees one code.
  always_comb begin
    in_cmd.data_byte = in_ch.data_byte;
    in_cmd.max_len   = in_ch.max_len;
    case (in_ch.action)
      ACT_PUSH:    in_cmd.action = ACT_PUSH;
      ACT_POP:     in_cmd.action = ACT_POP;
      ACT_EXTRACT: in_cmd.action = ACT_EXTRACT;
      default:     in_cmd.action = ACT_NOP;
    endcase
  end

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= in_cmd;
    end
  end

endmodule

`default_nettype wire

// ===== src/brf_back.sv =====
// Back end: byte ring memory, head and tail pointers, the delimiter scan
// sequencer and the result register. Depends on brf_pkg and brf_out_if.
`default_nettype none

module brf_back import brf_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic cmd_vld,
  input  cmd_t      cmd,
  output logic      cmd_take,
  input  cfg_t      cfg,
  brf_out_if.source out_ch
);

  localparam int PW = $clog2(DEPTH);
  localparam int SW = FILL_W + 1;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_CALC  = 3'd2;
  localparam logic [2:0] ST_EMIT  = 3'd3;
  localparam logic [2:0] ST_EMPTY = 3'd4;

  // Pointer plus an offset below DEPTH, wrapped once.
  function automatic logic [PW-1:0] ring_add(input logic [PW-1:0] base,
                                             input logic [FILL_W-1:0] off);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(off);
    if (sum >= SW'(DEPTH)) begin
      sum = sum - SW'(DEPTH);
    end
    return PW'(sum);
  endfunction

  logic [BYTE_W-1:0] byte_store [DEPTH];

  logic [2:0]        state_r, state_nxt;
  logic [PW-1:0]     head_r, head_nxt;
  logic [PW-1:0]     tail_r, tail_nxt;
  logic              chk_vld_r, chk_vld_nxt;
  logic              rdv_r, rdv_nxt;
  logic              ovld_r, ovld_nxt;

  logic [ACT_W-1:0]  act_r, act_nxt;
  logic [FILL_W-1:0] ml_r, ml_nxt;
  logic [FILL_W-1:0] f_r, f_nxt;
  logic              pa_r, pa_nxt;
  logic [FILL_W-1:0] s_r, s_nxt;
  logic [FILL_W-1:0] e_r, e_nxt;
  logic              phase_r, phase_nxt;
  logic [BYTE_W-1:0] prev_r, prev_nxt;
  logic [FILL_W-1:0] iss_off_r, iss_off_nxt;
  logic [PW-1:0]     iss_ptr_r, iss_ptr_nxt;
  logic [FILL_W-1:0] chk_off_r, chk_off_nxt;
  logic [PW-1:0]     ep_r, ep_nxt;
  logic [FILL_W-1:0] rem_r, rem_nxt;
  logic [FILL_W-1:0] rfill_r, rfill_nxt;
  logic              rd_last_r, rd_last_nxt;
  logic [BYTE_W-1:0] rd_data_r;
  logic [BYTE_W-1:0] obyte_r, obyte_nxt;
  logic              obv_r, obv_nxt;
  logic              olast_r, olast_nxt;
  logic              opa_r, opa_nxt;
  logic [FILL_W-1:0] ofill_r, ofill_nxt;

  logic              wr_en, rd_en;
  logic [PW-1:0]     rd_addr;
  logic [PW-1:0]     tail_inc;
  logic [SW-1:0]     fill_wide;
  logic [FILL_W-1:0] fill_cur;
  logic              out_free;
  logic              issue, move, found;
  logic [BYTE_W-1:0] end_sel;
  logic [FILL_W-1:0] c_len, c_n, c_st, c_hoff;
  logic              c_none;

  assign tail_inc  = ring_add(tail_r, FILL_W'(1));
  assign fill_wide = (tail_r >= head_r) ? SW'(tail_r) - SW'(head_r)
                                        : SW'(tail_r) + SW'(DEPTH) - SW'(head_r);
  assign fill_cur  = FILL_W'(fill_wide);
  assign out_free  = !ovld_r || out_ch.ready;
  assign end_sel   = (cfg.frame_mode == MODE_PAIR) ? cfg.end_char : cfg.start_char;

  // Frame length, byte count, start offset and new head offset, from the scan.
  always_comb begin
    c_len  = '0;
    c_st   = '0;
    c_none = 1'b0;
    if (act_r == ACT_POP) begin
      c_len = f_r;
    end else if (cfg.frame_mode == MODE_PAIR || cfg.frame_mode == MODE_SPLIT) begin
      c_len = e_r - s_r + 1'b1;
      c_st  = s_r;
    end else begin
      c_len = e_r + 1'b1;
    end
    c_n    = (c_len < ml_r) ? c_len : ml_r;
    c_hoff = c_n;
    if (act_r == ACT_EXTRACT) begin
      if (cfg.frame_mode == MODE_PAIR) begin
        c_hoff = e_r + 1'b1;
      end else if (cfg.frame_mode == MODE_SPLIT) begin
        // A short split frame is dropped but its closing delimiter stays.
        if (c_n <= FILL_W'(SHORT_FRAME)) begin
          c_none = 1'b1;
          c_hoff = (c_n != '0) ? s_r + c_n - 1'b1 : s_r;
        end else begin
          c_hoff = s_r + c_n;
        end
      end
    end
  end

  always_comb begin
    state_nxt   = state_r;
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    chk_vld_nxt = chk_vld_r;
    rdv_nxt     = rdv_r;
    act_nxt     = act_r;
    ml_nxt      = ml_r;
    f_nxt       = f_r;
    pa_nxt      = pa_r;
    s_nxt       = s_r;
    e_nxt       = e_r;
    phase_nxt   = phase_r;
    prev_nxt    = prev_r;
    iss_off_nxt = iss_off_r;
    iss_ptr_nxt = iss_ptr_r;
    chk_off_nxt = chk_off_r;
    ep_nxt      = ep_r;
    rem_nxt     = rem_r;
    rfill_nxt   = rfill_r;
    rd_last_nxt = rd_last_r;
    cmd_take    = 1'b0;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = iss_ptr_r;
    issue       = 1'b0;
    move        = 1'b0;
    found       = 1'b0;
    ovld_nxt    = out_ch.ready ? 1'b0 : ovld_r;
    obyte_nxt   = obyte_r;
    obv_nxt     = obv_r;
    olast_nxt   = olast_r;
    opa_nxt     = opa_r;
    ofill_nxt   = ofill_r;

    case (state_r)
      ST_IDLE: begin
        if (cmd_vld) begin
          cmd_take  = 1'b1;
          act_nxt   = cmd.action;
          ml_nxt    = cmd.max_len;
          f_nxt     = fill_cur;
          pa_nxt    = 1'b0;
          rfill_nxt = fill_cur;
          case (cmd.action)
            ACT_PUSH: begin
              if (tail_inc != head_r) begin
                wr_en     = 1'b1;
                tail_nxt  = tail_inc;
                pa_nxt    = 1'b1;
                rfill_nxt = fill_cur + 1'b1;
              end
              state_nxt = ST_EMPTY;
            end
            ACT_POP: begin
              state_nxt = ST_CALC;
            end
            ACT_EXTRACT: begin
              if (fill_cur == '0) begin
                state_nxt = ST_EMPTY;
              end else begin
                iss_off_nxt = '0;
                iss_ptr_nxt = head_r;
                chk_vld_nxt = 1'b0;
                phase_nxt   = 1'b0;
                prev_nxt    = '0;
                state_nxt   = ST_SCAN;
              end
            end
            default: begin
              state_nxt = ST_EMPTY;
            end
          endcase
        end
      end

      ST_SCAN: begin
        // Reads are issued one offset ahead of the compare.
        issue = (iss_off_r != f_r);
        if (issue) begin
          rd_en       = 1'b1;
          iss_ptr_nxt = ring_add(iss_ptr_r, FILL_W'(1));
          iss_off_nxt = iss_off_r + 1'b1;
        end
        chk_vld_nxt = issue;
        chk_off_nxt = iss_off_r;
        if (chk_vld_r) begin
          case (cfg.frame_mode)
            MODE_PAIR, MODE_SPLIT: begin
              if (!phase_r) begin
                if (rd_data_r == cfg.start_char) begin
                  s_nxt     = chk_off_r;
                  phase_nxt = 1'b1;
                end
              end else if (rd_data_r == end_sel) begin
                found = 1'b1;
              end
            end
            MODE_SINGLE: begin
              found = (rd_data_r == cfg.start_char);
            end
            default: begin
              found    = (prev_r == cfg.start_char) && (rd_data_r == cfg.end_char);
              prev_nxt = rd_data_r;
            end
          endcase
          if (found) begin
            e_nxt     = chk_off_r;
            state_nxt = ST_CALC;
          end else if (chk_off_r == f_r - 1'b1) begin
            rfill_nxt = f_r;
            state_nxt = ST_EMPTY;
          end
        end
      end

      ST_CALC: begin
        head_nxt  = ring_add(head_r, c_hoff);
        rfill_nxt = f_r - c_hoff;
        if (c_n == '0 || c_none) begin
          state_nxt = ST_EMPTY;
        end else begin
          ep_nxt    = ring_add(head_r, c_st);
          rem_nxt   = c_n;
          rdv_nxt   = 1'b0;
          state_nxt = ST_EMIT;
        end
      end

      ST_EMIT: begin
        move = rdv_r && out_free;
        if (move) begin
          ovld_nxt  = 1'b1;
          obyte_nxt = rd_data_r;
          obv_nxt   = 1'b1;
          olast_nxt = rd_last_r;
          opa_nxt   = 1'b0;
          ofill_nxt = rfill_r;
        end
        issue = (rem_r != '0) && (!rdv_r || move);
        if (issue) begin
          rd_en       = 1'b1;
          rd_addr     = ep_r;
          ep_nxt      = ring_add(ep_r, FILL_W'(1));
          rem_nxt     = rem_r - 1'b1;
          rdv_nxt     = 1'b1;
          rd_last_nxt = (rem_r == FILL_W'(1));
        end else if (move) begin
          rdv_nxt = 1'b0;
        end
        if (!issue && rem_r == '0 && (!rdv_r || move)) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_EMPTY: begin
        if (out_free) begin
          ovld_nxt  = 1'b1;
          obyte_nxt = '0;
          obv_nxt   = 1'b0;
          olast_nxt = 1'b1;
          opa_nxt   = pa_r;
          ofill_nxt = rfill_r;
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      head_r    <= '0;
      tail_r    <= '0;
      chk_vld_r <= 1'b0;
      rdv_r     <= 1'b0;
      ovld_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      head_r    <= head_nxt;
      tail_r    <= tail_nxt;
      chk_vld_r <= chk_vld_nxt;
      rdv_r     <= rdv_nxt;
      ovld_r    <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r     <= act_nxt;
    ml_r      <= ml_nxt;
    f_r       <= f_nxt;
    pa_r      <= pa_nxt;
    s_r       <= s_nxt;
    e_r       <= e_nxt;
    phase_r   <= phase_nxt;
    prev_r    <= prev_nxt;
    iss_off_r <= iss_off_nxt;
    iss_ptr_r <= iss_ptr_nxt;
    chk_off_r <= chk_off_nxt;
    ep_r      <= ep_nxt;
    rem_r     <= rem_nxt;
    rfill_r   <= rfill_nxt;
    rd_last_r <= rd_last_nxt;
    obyte_r   <= obyte_nxt;
    obv_r     <= obv_nxt;
    olast_r   <= olast_nxt;
    opa_r     <= opa_nxt;
    ofill_r   <= ofill_nxt;
  end

  // Ring memory: one write port for pushes, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      byte_store[tail_r] <= cmd.data_byte;
    end
    if (rd_en) begin
      rd_data_r <= byte_store[rd_addr];
    end
  end

  assign out_ch.valid         = ovld_r;
  assign out_ch.out_byte      = obyte_r;
  assign out_ch.byte_valid    = obv_r;
  assign out_ch.last          = olast_r;
  assign out_ch.push_accepted = opa_r;
  assign out_ch.fill_count    = ofill_r;

endmodule

`default_nettype wire

// ===== src/byte_ring_fifo_frame_extractor.sv =====
// Byte ring FIFO with delimiter framing on the read side.
// Channels: in_ch takes one word per action (push, pop or extract), out_ch
// returns one or more result words per action, the final one flagged last,
// and cfg_ch writes frame_mode, start_char and end_char. The user writes
// cfg_ch only while the block idles; the block itself does not enforce this.
// Every word is moved on a valid and ready handshake at a rising clock edge.
// The ring holds DEPTH-1 bytes in a single-port-write, registered-read memory.
// A push, a refused push, an unused action or an extract of an empty ring
// answers with one result word that carries no byte. A pop computes its byte
// count and then emits its bytes, or an empty result word if there are none.
// An extract scans the ring one entry per cycle through the memory read port,
// then computes the frame bounds and emits the frame's bytes; a frame that
// yields no bytes and a scan that finds no frame answer with an empty result
// word. Bytes follow one per cycle while the receiver does not stall. A new
// action starts once the previous one has loaded its last word.
// A two-word command queue sits in front, so input words are taken while the
// back end works or the receiver stalls; a stall holds the result register and
// the emit sequence in place. Reset clears pointers, the queue and the
// configuration; the ring contents are not cleared and no sweep is needed.
`default_nettype none

module byte_ring_fifo_frame_extractor import brf_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  brf_in_if.sink    in_ch,
  brf_out_if.source out_ch,
  brf_cfg_if.sink   cfg_ch
);

  cfg_t cfg_r, cfg_nxt;
  logic cmd_vld;
  logic cmd_take;
  cmd_t cmd;

  assign cfg_ch.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_FRAME_MODE: cfg_nxt.frame_mode = cfg_ch.data[MODE_W-1:0];
        CFG_START_CHAR: cfg_nxt.start_char = cfg_ch.data;
        CFG_END_CHAR:   cfg_nxt.end_char   = cfg_ch.data;
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  brf_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .cmd_vld  (cmd_vld),
    .cmd      (cmd),
    .cmd_take (cmd_take)
  );

  brf_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_vld  (cmd_vld),
    .cmd      (cmd),
    .cmd_take (cmd_take),
    .cfg      (cfg_r),
    .out_ch   (out_ch)
  );

endmodule

`default_nettype wire
